FILE: hdl/mset_pkg.sv
// shared types and constants of the timer slot table
package mset_pkg;

  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_CLEARED   = 3'd2;
  localparam logic [2:0] KIND_FIRED     = 3'd3;
  localparam logic [2:0] KIND_IDLE_TICK = 3'd4;

  // operation word handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [1:0]       action;
    logic [7:0]       handle;
    logic [31:0]      stamp;     // expiry for add, new tick count for tick
    logic [31:0]      period;
    logic             prot;
    logic             add_done;
    logic [2:0]       add_slot;
    logic [CNT_W-1:0] fire_cnt;
  } word_t;

  // firing report of one cell
  typedef struct packed {
    logic       fire;
    logic [2:0] slot;
    logic [7:0] handle;
  } fire_t;

endpackage

FILE: hdl/mset_if.sv
// input and result channel interfaces of the timer slot table
interface mset_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  handle;
  logic [31:0] first_delay;
  logic [31:0] reload_period;
  logic        protected_flag;

  modport source (output valid, action, handle, first_delay, reload_period,
                  protected_flag, input ready);
  modport sink (input valid, action, handle, first_delay, reload_period,
                protected_flag, output ready);
endinterface

interface mset_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] slot;
  logic [7:0] fired_handle;
  logic       last;

  modport source (output valid, kind, slot, fired_handle, last, input ready);
  modport sink (input valid, kind, slot, fired_handle, last, output ready);
endinterface

FILE: hdl/multi_slot_expiry_timer_table.sv
// top level of the timer slot table: input word, cell chain, result collection
// An input word (add, clear or tick) is accepted only while no earlier word is
// in flight. It then walks a chain of SLOT_COUNT cells, one cell per cycle
// while the result side keeps up, each cell holding one timer slot with its
// own 32-bit compare and add. The word is registered in the head register,
// in each cell and in the result register on its way to its last result. A
// waiting result stalls the whole chain. Fired timers are reported in slot
// order. Each firing is held back until a later firing or the end of the chain
// shows whether it is the final one, so that the final result can carry last.
// At most eight firings are reported per tick; further due slots stay due.
// Slots come out of reset free, with no clearing pass. Action code 3 walks
// the chain and gives no result.
module multi_slot_expiry_timer_table (
  input  logic clk_i,
  input  logic rst_ni,
  mset_in_if.sink    in_i,
  mset_out_if.source out_o
);
  import mset_pkg::*;

  logic        busy_q, busy_d;
  logic [31:0] now_q, now_d;
  word_t       head_q, head_d;
  word_t       words [SLOT_COUNT+1];
  fire_t       events [SLOT_COUNT];
  fire_t       ev_any;
  word_t       exit_word;
  logic        accept, advance;

  logic        pend_v_q, pend_v_d;
  logic [2:0]  pend_slot_q, pend_slot_d;
  logic [7:0]  pend_handle_q, pend_handle_d;

  logic        out_v_q, out_v_d;
  logic [2:0]  out_kind_q, out_kind_d;
  logic [2:0]  out_slot_q, out_slot_d;
  logic [7:0]  out_handle_q, out_handle_d;
  logic        out_last_q, out_last_d;
  logic        push;
  logic [2:0]  push_kind, push_slot;
  logic [7:0]  push_handle;
  logic        push_last;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign advance    = !out_v_q || out_o.ready;

  // load the operation word and step the tick count
  always_comb begin
    now_d  = now_q;
    head_d = head_q;
    if (accept) begin
      head_d.valid    = 1'b1;
      head_d.action   = in_i.action;
      head_d.handle   = in_i.handle;
      head_d.period   = in_i.reload_period;
      head_d.prot     = in_i.protected_flag;
      head_d.add_done = 1'b0;
      head_d.add_slot = 3'd0;
      head_d.fire_cnt = '0;
      if (in_i.action == ACT_TICK) begin
        now_d        = now_q + 32'd1;
        head_d.stamp = now_q + 32'd1;
      end else begin
        head_d.stamp = now_q + in_i.first_delay;
      end
    end else if (advance) begin
      head_d.valid = 1'b0;
    end
  end

  assign words[0] = head_q;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    mset_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .slot_i    (3'(i)),
      .word_i    (words[i]),
      .word_o    (words[i+1]),
      .event_o   (events[i])
    );
  end

  // only one cell sees a valid word at a time
  always_comb begin
    ev_any = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      ev_any = ev_any | events[i];
    end
  end

  assign exit_word = words[SLOT_COUNT];

  always_comb begin
    push        = 1'b0;
    push_kind   = KIND_ADDED;
    push_slot   = 3'd0;
    push_handle = 8'd0;
    push_last   = 1'b1;
    if (exit_word.valid) begin
      unique case (exit_word.action)
        ACT_ADD: begin
          push = 1'b1;
          if (exit_word.add_done) begin
            push_kind = KIND_ADDED;
            push_slot = exit_word.add_slot;
          end else begin
            push_kind = KIND_FULL;
          end
        end
        ACT_CLEAR: begin
          push      = 1'b1;
          push_kind = KIND_CLEARED;
        end
        ACT_TICK: begin
          push = 1'b1;
          if (pend_v_q) begin
            push_kind   = KIND_FIRED;
            push_slot   = pend_slot_q;
            push_handle = pend_handle_q;
          end else begin
            push_kind = KIND_IDLE_TICK;
          end
        end
        default: begin
        end
      endcase
    end else if (ev_any.fire && pend_v_q) begin
      // a newer firing proves the held one is not the final word
      push        = 1'b1;
      push_kind   = KIND_FIRED;
      push_slot   = pend_slot_q;
      push_handle = pend_handle_q;
      push_last   = 1'b0;
    end
  end

  always_comb begin
    busy_d        = busy_q;
    pend_v_d      = pend_v_q;
    pend_slot_d   = pend_slot_q;
    pend_handle_d = pend_handle_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (advance && exit_word.valid) begin
      busy_d = 1'b0;
    end
    if (advance) begin
      if (exit_word.valid) begin
        pend_v_d = 1'b0;
      end else if (ev_any.fire) begin
        pend_v_d      = 1'b1;
        pend_slot_d   = ev_any.slot;
        pend_handle_d = ev_any.handle;
      end
    end
  end

  always_comb begin
    out_v_d      = out_v_q;
    out_kind_d   = out_kind_q;
    out_slot_d   = out_slot_q;
    out_handle_d = out_handle_q;
    out_last_d   = out_last_q;
    if (advance && push) begin
      out_v_d      = 1'b1;
      out_kind_d   = push_kind;
      out_slot_d   = push_slot;
      out_handle_d = push_handle;
      out_last_d   = push_last;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      now_q    <= 32'd0;
      head_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      now_q    <= now_d;
      head_q   <= head_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q   <= pend_slot_d;
    pend_handle_q <= pend_handle_d;
    out_kind_q    <= out_kind_d;
    out_slot_q    <= out_slot_d;
    out_handle_q  <= out_handle_d;
    out_last_q    <= out_last_d;
  end

  assign out_o.valid        = out_v_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.slot         = out_slot_q;
  assign out_o.fired_handle = out_handle_q;
  assign out_o.last         = out_last_q;

endmodule

FILE: hdl/mset_cell.sv
// one timer slot cell: holds a slot and passes the operation word on
module mset_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [2:0]      slot_i,
  input  mset_pkg::word_t word_i,
  output mset_pkg::word_t word_o,
  output mset_pkg::fire_t event_o
);
  import mset_pkg::*;

  logic [7:0]  handle_q, handle_d;
  logic        prot_q, prot_d;
  logic [31:0] expiry_q, expiry_d;
  logic [31:0] period_q, period_d;
  word_t       word_q, word_d;

  always_comb begin
    word_d     = word_i;
    handle_d   = handle_q;
    prot_d     = prot_q;
    expiry_d   = expiry_q;
    period_d   = period_q;
    event_o    = '0;
    if (word_i.valid) begin
      unique case (word_i.action)
        ACT_ADD: begin
          if (!word_i.add_done && handle_q == 8'd0) begin
            handle_d        = word_i.handle;
            prot_d          = word_i.prot;
            expiry_d        = word_i.stamp;
            period_d        = word_i.period;
            word_d.add_done = 1'b1;
            word_d.add_slot = slot_i;
          end
        end
        ACT_CLEAR: begin
          if (!prot_q) begin
            handle_d = 8'd0;
          end
        end
        ACT_TICK: begin
          if (handle_q != 8'd0 && expiry_q < word_i.stamp &&
              word_i.fire_cnt < CNT_W'(MAX_RESULTS)) begin
            expiry_d        = expiry_q + period_q;
            word_d.fire_cnt = word_i.fire_cnt + CNT_W'(1);
            event_o.fire    = 1'b1;
            event_o.slot    = slot_i;
            event_o.handle  = handle_q;
            if (period_q == 32'd0) begin
              handle_d = 8'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handle_q <= 8'd0;
      prot_q   <= 1'b0;
      word_q   <= '0;
    end else if (advance_i) begin
      handle_q <= handle_d;
      prot_q   <= prot_d;
      word_q   <= word_d;
    end
  end

  // expiry and period are only read once an add has written them
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      expiry_q <= expiry_d;
      period_q <= period_d;
    end
  end

  assign word_o = word_q;

endmodule
